[sv/height_hold_pid_core_assert.svh]
// Assertion macros for the height hold PID core
`ifndef HEIGHT_HOLD_PID_CORE_ASSERT_SVH
`define HEIGHT_HOLD_PID_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset
`define HHP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define HHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HHP_ASSERT_IMPLY(label, ante, cons, msg)
`define HHP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/hhp_pkg.sv]
// Constants and codes shared by the height hold PID core
`default_nettype none

package hhp_pkg;

    // Operand widths
    localparam int DIST_W  = 12;
    localparam int THR_W   = 10;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 13;
    localparam int DRIVE_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Height limit and integral clamp
    localparam logic [DIST_W-1:0]       MAX_HEIGHT  = 12'd1000;
    localparam logic signed [ERR_W:0]   INTEG_LIMIT = 14'sd3000;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;
    localparam logic [DIST_W-1:0] TARGET_RST = 12'd700;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GAIN_P = 3'd0;
    localparam cfg_idx_t CFG_GAIN_I = 3'd1;
    localparam cfg_idx_t CFG_GAIN_D = 3'd2;
    localparam cfg_idx_t CFG_HOLD   = 3'd3;
    localparam cfg_idx_t CFG_TARGET = 3'd4;

    // Drive saturation bounds, at the width of the control sum
    localparam logic signed [DRIVE_W+1:0] DRIVE_MAX = 26'sd8388607;
    localparam logic signed [DRIVE_W+1:0] DRIVE_MIN = -26'sd8388608;

endpackage

`default_nettype wire

[sv/height_hold_pid_core.sv]
// Height hold controller: positional PID with integral clamp and held drive output
`default_nettype none
// Path: an accepted input item waits in the input register; its result item is
// then registered in the result register, which drives m_tvalid and m_tdata.
// Throughput: one item per cycle while m_tready allows; the PID math sits between the input
// register and the result register, and the PID state closes its loop in that one stage.
// Reset (rst_n low, asynchronous): pipeline empty, PID state zero, gains and
// target back to their defaults (gain_p 1.0, target 700 mm, pass-through mode).

module height_hold_pid_core
    import hhp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input item stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // [11:0] measured_distance, [21:12] throttle
    input  wire logic                  s_tuser,   // [0] new_sample
    // result item stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [23:0] drive_out (signed)
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire cfg_idx_t              cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "height_hold_pid_core_assert.svh"

    // Configuration registers
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;
    logic              hold_reg;
    logic [DIST_W-1:0] target_reg;

    // Input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_fresh_reg;
    logic [DIST_W-1:0] in_dist_reg;
    logic [THR_W-1:0]  in_thr_reg;

    // PID state
    logic signed [ERR_W-1:0]   integ_reg;
    logic signed [ERR_W-1:0]   integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   prev_err_next;
    logic signed [DRIVE_W-1:0] held_reg;
    logic signed [DRIVE_W-1:0] held_next;

    // Result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DRIVE_W-1:0] out_data_reg;
    logic [DRIVE_W-1:0] out_data_next;

    // Datapath
    logic               in_accept;
    logic               advance;
    logic [DIST_W-1:0]  tgt_lim;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W:0]     err_ext;
    logic signed [ERR_W:0]     integ_raw;
    logic signed [ERR_W-1:0]   integ_clamp;
    logic signed [ERR_W:0]     deriv;
    logic signed [GAIN_W:0]    gp_s;
    logic signed [GAIN_W:0]    gi_s;
    logic signed [GAIN_W:0]    gd_s;
    logic signed [ERR_W:0]     integ_op;
    logic signed [30:0]        p_prod;
    logic signed [30:0]        i_prod;
    logic signed [30:0]        d_prod;
    logic signed [32:0]        pid_sum;
    logic signed [32:0]        pid_biased;
    logic signed [DRIVE_W:0]   pid_round;
    logic signed [DRIVE_W+1:0] ctrl;
    logic signed [DRIVE_W-1:0] ctrl_sat;

    // Handshakes: the result register frees when taken, the input register when it advances
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
            hold_reg   <= 1'b0;
            target_reg <= TARGET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN_P: gain_p_reg <= cfg_data;
                CFG_GAIN_I: gain_i_reg <= cfg_data;
                CFG_GAIN_D: gain_d_reg <= cfg_data;
                CFG_HOLD:   hold_reg   <= cfg_data[0];
                CFG_TARGET: target_reg <= cfg_data[DIST_W-1:0];
                default:    ;
            endcase
        end
    end

    // Limit the target and form error, clamped integral and derivative
    always_comb
    begin
        tgt_lim     = (target_reg > MAX_HEIGHT) ? MAX_HEIGHT : target_reg;
        err         = $signed({1'b0, tgt_lim}) - $signed({1'b0, in_dist_reg});
        err_ext     = {err[ERR_W-1], err};
        integ_raw   = {integ_reg[ERR_W-1], integ_reg} + err_ext;
        if (integ_raw > INTEG_LIMIT)
        begin
            integ_clamp = INTEG_LIMIT[ERR_W-1:0];
        end
        else if (integ_raw < -INTEG_LIMIT)
        begin
            integ_clamp = ERR_W'(-INTEG_LIMIT);
        end
        else
        begin
            integ_clamp = integ_raw[ERR_W-1:0];
        end
        deriv       = err_ext - {prev_err_reg[ERR_W-1], prev_err_reg};
    end

    // Multiply by the Q8.8 gains, sum, round half up, add throttle and saturate
    always_comb
    begin
        gp_s       = $signed({1'b0, gain_p_reg});
        gi_s       = $signed({1'b0, gain_i_reg});
        gd_s       = $signed({1'b0, gain_d_reg});
        integ_op   = {integ_clamp[ERR_W-1], integ_clamp};
        p_prod     = gp_s * err_ext;
        i_prod     = gi_s * integ_op;
        d_prod     = gd_s * deriv;
        pid_sum    = 33'(p_prod) + 33'(i_prod) + 33'(d_prod);
        pid_biased = pid_sum + 33'sd128;
        pid_round  = pid_biased[32:8];
        ctrl       = 26'(pid_round) + $signed({16'd0, in_thr_reg});
        if (ctrl > DRIVE_MAX)
        begin
            ctrl_sat = DRIVE_MAX[DRIVE_W-1:0];
        end
        else if (ctrl < DRIVE_MIN)
        begin
            ctrl_sat = DRIVE_MIN[DRIVE_W-1:0];
        end
        else
        begin
            ctrl_sat = ctrl[DRIVE_W-1:0];
        end
    end

    // Next state: update PID state on a fresh item, pick held drive or throttle
    always_comb
    begin
        in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        held_next      = held_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_valid_reg && advance)
        begin
            if (in_fresh_reg)
            begin
                integ_next    = integ_clamp;
                prev_err_next = err;
                held_next     = ctrl_sat;
            end
            out_data_next = hold_reg ? held_next : {{(DRIVE_W-THR_W){1'b0}}, in_thr_reg};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            held_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            held_reg      <= held_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_fresh_reg <= s_tuser;
            in_dist_reg  <= s_tdata[DIST_W-1:0];
            in_thr_reg   <= s_tdata[DIST_W+THR_W-1:DIST_W];
        end
        out_data_reg <= out_data_next;
    end

    // Checks
    `HHP_ASSERT_IMPLY(a_integ_range, 1'b1,
        (integ_reg <= $signed(INTEG_LIMIT[ERR_W-1:0])) && (integ_reg >= ERR_W'(-INTEG_LIMIT)),
        "integral left its clamp range")
    `HHP_ASSERT_NEXT(a_stalled_item_kept, in_valid_reg && !advance,
        in_valid_reg, "input item dropped while stalled")
    `HHP_ASSERT_NEXT(a_stale_keeps_state, in_valid_reg && advance && !in_fresh_reg,
        $stable(integ_reg) && $stable(prev_err_reg) && $stable(held_reg),
        "PID state changed without a fresh sample")
    `HHP_ASSERT_NEXT(a_pass_gives_throttle, in_valid_reg && advance && !hold_reg,
        out_valid_reg && (out_data_reg == {{(DRIVE_W-THR_W){1'b0}}, $past(in_thr_reg)}),
        "pass mode result differs from throttle")

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the height hold PID core: directed table, random phases
`default_nettype none

module testbench;
    import hhp_pkg::*;

    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 12;
    localparam int WATCH_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;
    localparam int NUM_ROWS      = 30;

    // Indexes past the register list; writes there must change nothing
    localparam cfg_idx_t CFG_SPARE_LO = 3'd5;
    localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

    // One line of the directed script: a register write or an input item
    typedef struct packed {
        logic                  is_reg;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  fresh;
        logic [DIST_W-1:0]     dist_mm;
        logic [THR_W-1:0]      thr;
        logic                  typed;
        logic [DRIVE_W-1:0]    drive;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register shadows
    logic [GAIN_W-1:0]        shadow_gain_p;
    logic [GAIN_W-1:0]        shadow_gain_i;
    logic [GAIN_W-1:0]        shadow_gain_d;
    logic                     shadow_hold;
    logic [DIST_W-1:0]        shadow_target;

    // Controller state as the block keeps it
    logic signed [ERR_W-1:0]   pid_integ;
    logic signed [ERR_W-1:0]   pid_prev_err;
    logic signed [DRIVE_W-1:0] pid_held;

    logic [DRIVE_W-1:0] pending_drive [$];

    int  err_count;
    int  n_items;
    int  n_fresh;
    int  n_clamps;
    int  n_checked;
    int  n_hold_results;
    int  n_settings;
    int  idle_cycles;
    bit  calm;
    bit  long_hold_req;

    script_row_t script [0:NUM_ROWS-1] = '{
        // pass mode after reset: drive follows throttle, state still advances
        '{1'b0, '0, 16'd0, 1'b0, 12'd0,    10'd0,    1'b1, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd4095, 10'd1023, 1'b1, 24'd1023},
        '{1'b0, '0, 16'd0, 1'b1, 12'd0,    10'd1000, 1'b1, 24'd1000},
        '{1'b0, '0, 16'd0, 1'b0, 12'hAAA,  10'h155,  1'b1, 24'h000155},
        '{1'b0, '0, 16'd0, 1'b1, 12'h555,  10'h2AA,  1'b1, 24'h0002AA},
        // hold mode with unity proportional gain
        '{1'b1, CFG_HOLD, 16'd1, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b0, 12'd0,    10'd0,    1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd700,  10'd500,  1'b1, 24'd500},
        '{1'b0, '0, 16'd0, 1'b1, 12'd0,    10'd0,    1'b1, 24'd700},
        '{1'b0, '0, 16'd0, 1'b1, 12'd4095, 10'd0,    1'b1, -24'sd3395},
        // target above the height limit
        '{1'b1, CFG_TARGET, 16'd4095, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd0,    10'd0,    1'b1, 24'd1000},
        '{1'b0, '0, 16'd0, 1'b0, 12'd123,  10'd999,  1'b1, 24'd1000},
        // full gains, drive the integral into its lower clamp
        '{1'b1, CFG_GAIN_P, 16'hFFFF, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b1, CFG_GAIN_I, 16'hFFFF, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b1, CFG_GAIN_D, 16'hFFFF, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd4095, 10'd1023, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd4095, 10'd1023, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd4095, 10'd0,    1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd0,    10'd1023, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd0,    10'd0,    1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd0,    10'd0,    1'b0, 24'd0},
        // all gains zero: drive is the throttle alone
        '{1'b1, CFG_GAIN_P, 16'd0, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b1, CFG_GAIN_I, 16'd0, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b1, CFG_GAIN_D, 16'd0, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b1, 12'd321,  10'd77,   1'b1, 24'd77},
        // writes past the register list are dropped
        '{1'b1, CFG_SPARE_LO, 16'hFFFF, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b1, CFG_SPARE_HI, 16'h1234, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0},
        '{1'b0, '0, 16'd0, 1'b0, 12'd0,    10'd5,    1'b1, 24'd77},
        '{1'b1, CFG_HOLD, 16'd0, 1'b0, 12'd0, 10'd0, 1'b0, 24'd0}
    };

    height_hold_pid_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_fail(input string msg);
        if (err_count < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Mirror a register write into the shadows
    task automatic apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P: shadow_gain_p = data;
            CFG_GAIN_I: shadow_gain_i = data;
            CFG_GAIN_D: shadow_gain_d = data;
            CFG_HOLD:   shadow_hold   = data[0];
            CFG_TARGET: shadow_target = data[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // Advance the controller by one tick and return the drive it puts out
    function automatic logic [DRIVE_W-1:0] predict_drive(input logic fresh,
                                                         input logic [DIST_W-1:0] dist_mm,
                                                         input logic [THR_W-1:0] thr);
        logic [DIST_W-1:0] tgt;
        longint            err;
        longint            integ;
        longint            lim;
        longint            acc;
        longint            ctrl;
        if (fresh)
        begin
            tgt   = (shadow_target > MAX_HEIGHT) ? MAX_HEIGHT : shadow_target;
            err   = longint'(tgt) - longint'(dist_mm);
            lim   = longint'(INTEG_LIMIT);
            integ = longint'(pid_integ) + err;
            if (integ > lim || integ < -lim)
                n_clamps++;
            if (integ > lim)
                integ = lim;
            else if (integ < -lim)
                integ = -lim;
            acc = longint'(shadow_gain_p) * err
                + longint'(shadow_gain_i) * integ
                + longint'(shadow_gain_d) * (err - longint'(pid_prev_err));
            // round half up out of Q8.8
            ctrl = longint'(thr) + ((acc + 128) >>> 8);
            if (ctrl > longint'(DRIVE_MAX))
                ctrl = longint'(DRIVE_MAX);
            else if (ctrl < longint'(DRIVE_MIN))
                ctrl = longint'(DRIVE_MIN);
            pid_integ    = integ[ERR_W-1:0];
            pid_prev_err = err[ERR_W-1:0];
            pid_held     = ctrl[DRIVE_W-1:0];
        end
        return shadow_hold ? pid_held : {{(DRIVE_W-THR_W){1'b0}}, thr};
    endfunction

    // Offer one item, record its drive once taken, then maybe pause
    task automatic send_sample(input logic fresh, input logic [DIST_W-1:0] dist_mm,
                               input logic [THR_W-1:0] thr, input logic typed,
                               input logic [DRIVE_W-1:0] typed_drive);
        logic [DRIVE_W-1:0] want;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, thr, dist_mm};
        s_tuser  <= fresh;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_drive(fresh, dist_mm, thr);
        pending_drive.push_back(typed ? typed_drive : want);
        n_items++;
        if (fresh)
            n_fresh++;
        if (shadow_hold)
            n_hold_results++;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every drive has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return GAIN_W'($urandom());
            default: return GAIN_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_target();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return MAX_HEIGHT;
            default: return DIST_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Distance: near the effective target in three of ten picks, anywhere in five, at the ends in two
    function automatic logic [DIST_W-1:0] pick_distance();
        int base;
        int d;
        base = (shadow_target > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(shadow_target);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: begin
                d = base + $urandom_range(0, 128) - 64;
                if (d < 0)
                    d = 0;
                return DIST_W'(d);
            end
            default: return DIST_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_throttle();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return THR_W'($urandom_range(1001, 1023));
            default: return THR_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin : drain_side
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each drive taken against the oldest one owed
    always @(posedge clk)
    begin : check_drive
        logic [DRIVE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drive.size() == 0)
                report_fail($sformatf("drive_out %0d with nothing owed",
                                      $signed(m_tdata)));
            else
            begin
                want = pending_drive.pop_front();
                n_checked++;
                if (m_tdata !== want)
                    report_fail($sformatf("drive_out got %0d want %0d",
                                          $signed(m_tdata), $signed(want)));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCH_LIMIT);
            $display("[height_hold_pid_core] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        idle_cycles   = 0;
        err_count     = 0;
        n_items       = 0;
        n_fresh       = 0;
        n_clamps      = 0;
        n_checked     = 0;
        n_hold_results = 0;
        n_settings    = 1;
        shadow_gain_p = GAIN_P_RST;
        shadow_gain_i = GAIN_I_RST;
        shadow_gain_d = GAIN_D_RST;
        shadow_hold   = 1'b0;
        shadow_target = TARGET_RST;
        pid_integ     = '0;
        pid_prev_err  = '0;
        pid_held      = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed script
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (script[r].is_reg)
            begin
                wait_idle();
                write_reg(script[r].idx, script[r].data);
                n_settings++;
            end
            else
                send_sample(script[r].fresh, script[r].dist_mm, script[r].thr,
                            script[r].typed, script[r].drive);
        end

        // Random phases, each with a fresh register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            calm = (p == NUM_PHASES - 1);
            write_reg(CFG_GAIN_P, pick_gain());
            write_reg(CFG_GAIN_I, pick_gain());
            write_reg(CFG_GAIN_D, pick_gain());
            write_reg(CFG_TARGET, 16'(pick_target()));
            write_reg(CFG_HOLD, 16'($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE_HI, 16'($urandom()));
            n_settings++;
            // stall the result side long enough to back up the input
            if (p == 2)
                long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_sample($urandom_range(0, 9) < 7, pick_distance(), pick_throttle(),
                            1'b0, '0);
                // pause the input once until the pipeline is empty
                if (p == 5 && k == PHASE_ITEMS / 2)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_drive.size() != 0)
            report_fail($sformatf("%0d drive values never arrived", pending_drive.size()));

        $display("Covered %0d items (%0d fresh samples, %0d integral clamps) over %0d settings",
                 n_items, n_fresh, n_clamps, n_settings);
        $display("Compared %0d drive values, %0d in hold mode, %0d mismatches",
                 n_checked, n_hold_results, err_count);
        if (err_count == 0)
            $display("[height_hold_pid_core] OK");
        else
            $display("[height_hold_pid_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
